// ===== rtl/gud_pkg.sv =====
`default_nettype none

package gud_pkg;

  localparam int FIELD_TYPES = 4;
  localparam int RESULT_CAP  = 64;
  localparam int RES_W       = $clog2(RESULT_CAP + 1);

  typedef struct packed {
    logic [7:0]                  id;
    logic [19:0]                 travel;
    logic [FIELD_TYPES-1:0][7:0] avail;
  } station_t;

  typedef struct packed {
    logic [7:0]  id;
    logic [19:0] travel;
    logic [7:0]  amt;
  } res_t;

  typedef struct packed {
    logic start;
    logic step;
  } lane_ctl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_SUM,
    ST_DRAIN,
    ST_FETCH,
    ST_NOOP
  } state_t;

endpackage

`default_nettype wire

// ===== rtl/gud_lane.sv =====
`default_nettype none

module gud_lane import gud_pkg::*; #(
  parameter int MAX_STATIONS = 16,
  parameter int LANE         = 0,
  localparam int CW = $clog2(MAX_STATIONS + 1),
  localparam int AW = (MAX_STATIONS > 1) ? $clog2(MAX_STATIONS) : 1
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire lane_ctl_t          ctl,
  input  wire logic [7:0]         req,
  input  wire logic [7:0]         held,
  input  wire logic signed [20:0] secs,
  input  wire station_t           station,
  input  wire logic [AW-1:0]      rd_addr,
  output logic [CW-1:0]           cnt,
  output res_t                    rd_data
);

  logic [7:0]    need_r;
  logic [7:0]    sent_r;
  logic          stop_r;
  logic [CW-1:0] cnt_r;
  res_t          buf_mem [MAX_STATIONS];
  res_t          rd_data_r;

  logic [7:0]         av;
  logic [7:0]         remain;
  logic [7:0]         amt;
  logic [7:0]         need_in;
  logic signed [21:0] tt_s;
  logic signed [21:0] secs_x;
  logic               met;
  logic               late;
  logic               emit;
  logic               halt;

  always_comb begin
    av      = station.avail[LANE];
    remain  = need_r - sent_r;
    amt     = (av < remain) ? av : remain;
    need_in = (req > held) ? (req - held) : 8'd0;
    tt_s    = {2'b00, station.travel};
    secs_x  = {secs[20], secs};
    met     = (sent_r >= need_r);
    late    = (tt_s >= secs_x);
    // an empty station is skipped before the time check
    emit    = ctl.step && !stop_r && !met && (av != 8'd0) && !late;
    halt    = ctl.step && !stop_r && (met || ((av != 8'd0) && late));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      need_r <= '0;
      sent_r <= '0;
      stop_r <= 1'b0;
      cnt_r  <= '0;
    end else if (ctl.start) begin
      need_r <= need_in;
      sent_r <= '0;
      stop_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      if (emit) begin
        sent_r <= sent_r + amt;
        cnt_r  <= cnt_r + CW'(1);
      end
      if (halt) begin
        stop_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      buf_mem[cnt_r[AW-1:0]] <= '{id: station.id, travel: station.travel, amt: amt};
    end
    rd_data_r <= buf_mem[rd_addr];
  end

  assign cnt     = cnt_r;
  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ===== rtl/greedy_unit_dispatch_allocator.sv =====
`default_nettype none

// Channel | Direction | Handshake            | Payload
// in      | input     | in_valid / in_ready  | kind, index, seconds, qty_0..3, held_0..3
// out     | output    | out_valid / out_ready| dispatch, station_id, incident_no,
//         |           |                      | unit_type, amount, travel_time, last
//
// A request walks all types at once (one station a cycle through the table read port, one
// lane per type), then reads each result from the lane buffers, passing over the lanes
// with no results. Reset clears the station count and all control state; table contents
// stay unknown.
// A stalled out_ready holds the pending result; input is taken only while idle, also
// while the final result of the previous request still waits.

module greedy_unit_dispatch_allocator import gud_pkg::*; #(
  parameter int MAX_STATIONS = 16,
  parameter int NUM_TYPES    = 4
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               in_kind,
  input  wire logic signed [8:0]  in_index,
  input  wire logic signed [20:0] in_seconds,
  input  wire logic [7:0]         in_qty_0,
  input  wire logic [7:0]         in_qty_1,
  input  wire logic [7:0]         in_qty_2,
  input  wire logic [7:0]         in_qty_3,
  input  wire logic [7:0]         in_held_0,
  input  wire logic [7:0]         in_held_1,
  input  wire logic [7:0]         in_held_2,
  input  wire logic [7:0]         in_held_3,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic                    out_dispatch,
  output logic [7:0]              out_station_id,
  output logic [7:0]              out_incident_no,
  output logic [1:0]              out_unit_type,
  output logic [7:0]              out_amount,
  output logic [19:0]             out_travel_time,
  output logic                    out_last
);

  localparam int CW    = $clog2(MAX_STATIONS + 1);
  localparam int AW    = (MAX_STATIONS > 1) ? $clog2(MAX_STATIONS) : 1;
  localparam int LANES = (NUM_TYPES < FIELD_TYPES) ? NUM_TYPES : FIELD_TYPES;
  localparam int LW    = (LANES > 1) ? $clog2(LANES) : 1;
  localparam int SW    = (CW + 3 > RES_W + 1) ? CW + 3 : RES_W + 1;

  state_t state_r, state_nxt;

  logic [CW-1:0]      station_count_r;
  logic [CW-1:0]      walk_len_r;
  logic [CW-1:0]      issue_r;
  logic               tbl_vld_r;
  logic signed [20:0] secs_r;
  logic [7:0]         incident_r;
  station_t           tbl_mem [MAX_STATIONS];
  station_t           tbl_rd_r;
  logic [RES_W-1:0]   total_r;
  logic [RES_W-1:0]   emit_r;
  logic [LW-1:0]      lane_sel_r;
  logic [CW-1:0]      rd_ptr_r;

  logic               out_valid_r;
  logic               out_dispatch_r;
  logic [7:0]         out_station_id_r;
  logic [7:0]         out_incident_no_r;
  logic [1:0]         out_unit_type_r;
  logic [7:0]         out_amount_r;
  logic [19:0]        out_travel_time_r;
  logic               out_last_r;

  logic [FIELD_TYPES-1:0][7:0] qty_a;
  logic [FIELD_TYPES-1:0][7:0] held_a;
  logic [CW-1:0]               lane_cnt [LANES];
  res_t                        lane_rd  [LANES];
  lane_ctl_t                   lane_ctl;

  logic             in_acc;
  logic             out_free;
  logic             load_station;
  logic             start_req;
  logic             issue;
  logic             lane_adv;
  logic             load_res;
  logic             load_noop;
  logic             is_last;
  logic [CW-1:0]    cur_cnt;
  logic [SW-1:0]    sum;
  logic [RES_W-1:0] sum_cap;
  station_t         new_station;

  assign qty_a  = {in_qty_3, in_qty_2, in_qty_1, in_qty_0};
  assign held_a = {in_held_3, in_held_2, in_held_1, in_held_0};

  assign in_acc   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign cur_cnt  = lane_cnt[lane_sel_r];
  assign is_last  = (RES_W'(emit_r + RES_W'(1)) == total_r);

  always_comb begin
    sum = '0;
    for (int l = 0; l < LANES; l++) begin
      sum = sum + SW'(lane_cnt[l]);
    end
    sum_cap = (sum > SW'(RESULT_CAP)) ? RES_W'(RESULT_CAP) : RES_W'(sum);
  end

  always_comb begin
    new_station.id     = in_index[7:0];
    new_station.travel = in_seconds[20] ? 20'd0 : in_seconds[19:0];
    new_station.avail  = qty_a;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_acc && in_kind) state_nxt = ST_WALK;
      ST_WALK:  if (issue_r == walk_len_r && !tbl_vld_r) state_nxt = ST_SUM;
      ST_SUM:   state_nxt = (sum_cap == '0) ? ST_NOOP : ST_DRAIN;
      ST_DRAIN: if (rd_ptr_r != cur_cnt) state_nxt = ST_FETCH;
      ST_FETCH: if (out_free) state_nxt = is_last ? ST_IDLE : ST_DRAIN;
      ST_NOOP:  if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_ready     = 1'b0;
    issue        = 1'b0;
    lane_adv     = 1'b0;
    load_res     = 1'b0;
    load_noop    = 1'b0;
    unique case (state_r)
      ST_IDLE:  in_ready  = 1'b1;
      ST_WALK:  issue     = (issue_r != walk_len_r);
      ST_SUM:   ;
      ST_DRAIN: lane_adv  = (rd_ptr_r == cur_cnt);
      ST_FETCH: load_res  = out_free;
      ST_NOOP:  load_noop = out_free;
      default:  ;
    endcase
    load_station = in_acc && !in_kind && (station_count_r < CW'(MAX_STATIONS));
    start_req    = in_acc && in_kind;
  end

  assign lane_ctl = '{start: start_req, step: tbl_vld_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= ST_IDLE;
      station_count_r <= '0;
      walk_len_r      <= '0;
      issue_r         <= '0;
      tbl_vld_r       <= 1'b0;
      total_r         <= '0;
      emit_r          <= '0;
      lane_sel_r      <= '0;
      rd_ptr_r        <= '0;
      out_valid_r     <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      tbl_vld_r <= issue;
      if (load_station) begin
        station_count_r <= station_count_r + CW'(1);
      end
      if (start_req) begin
        // a negative incident walks nothing; every request clears the list
        walk_len_r      <= in_index[8] ? '0 : station_count_r;
        station_count_r <= '0;
        issue_r         <= '0;
        emit_r          <= '0;
        lane_sel_r      <= '0;
        rd_ptr_r        <= '0;
      end
      if (issue) begin
        issue_r <= issue_r + CW'(1);
      end
      if (state_r == ST_SUM) begin
        total_r <= sum_cap;
      end
      if (lane_adv) begin
        lane_sel_r <= lane_sel_r + LW'(1);
        rd_ptr_r   <= '0;
      end
      if (load_res) begin
        rd_ptr_r <= rd_ptr_r + CW'(1);
        emit_r   <= emit_r + RES_W'(1);
      end
      if (load_res || load_noop) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start_req) begin
      secs_r     <= in_seconds;
      incident_r <= in_index[7:0];
    end
    if (load_res) begin
      out_dispatch_r    <= 1'b1;
      out_station_id_r  <= lane_rd[lane_sel_r].id;
      out_incident_no_r <= incident_r;
      out_unit_type_r   <= 2'(lane_sel_r);
      out_amount_r      <= lane_rd[lane_sel_r].amt;
      out_travel_time_r <= lane_rd[lane_sel_r].travel;
      out_last_r        <= is_last;
    end else if (load_noop) begin
      out_dispatch_r    <= 1'b0;
      out_station_id_r  <= '0;
      out_incident_no_r <= '0;
      out_unit_type_r   <= '0;
      out_amount_r      <= '0;
      out_travel_time_r <= '0;
      out_last_r        <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load_station) begin
      tbl_mem[station_count_r[AW-1:0]] <= new_station;
    end
    tbl_rd_r <= tbl_mem[issue_r[AW-1:0]];
  end

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    gud_lane #(
      .MAX_STATIONS(MAX_STATIONS),
      .LANE        (l)
    ) u_lane (
      .clk    (clk),
      .rst_n  (rst_n),
      .ctl    (lane_ctl),
      .req    (qty_a[l]),
      .held   (held_a[l]),
      .secs   (secs_r),
      .station(tbl_rd_r),
      .rd_addr(rd_ptr_r[AW-1:0]),
      .cnt    (lane_cnt[l]),
      .rd_data(lane_rd[l])
    );
  end

  assign out_valid       = out_valid_r;
  assign out_dispatch    = out_dispatch_r;
  assign out_station_id  = out_station_id_r;
  assign out_incident_no = out_incident_no_r;
  assign out_unit_type   = out_unit_type_r;
  assign out_amount      = out_amount_r;
  assign out_travel_time = out_travel_time_r;
  assign out_last        = out_last_r;

endmodule

`default_nettype wire
